[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define DEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DEQ_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_LIST_FWD   = 3'd4,
    CMD_LIST_BWD   = 3'd5
  } cmd_t;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // CELL_UP: take the lower-index neighbor, CELL_DOWN: take the higher-index one
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             load_en;
    logic [IDX_W-1:0] load_index;
  } chain_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } deq_state_t;

endpackage

[rtl/deq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the chain: holds, shifts from a neighbor, or loads.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; (
  input  logic               clk,
  input  cell_op_t           op,
  input  logic               load,
  input  logic [VALUE_W-1:0] load_value,
  input  logic [VALUE_W-1:0] lower,
  input  logic [VALUE_W-1:0] upper,
  output logic [VALUE_W-1:0] value
);

  logic [VALUE_W-1:0] value_next;

  always_comb begin
    value_next = value;
    if (load) begin
      value_next = load_value;
    end else begin
      case (op)
        CELL_UP:   value_next = lower;
        CELL_DOWN: value_next = upper;
        default:   value_next = value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[rtl/deq_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_chain
// Row of DEPTH cells with neighbor links and one decoded load position.
// ----------------------------------------------------------------------------
module deq_chain import deq_pkg::*; (
  input  logic               clk,
  input  chain_ctl_t         ctl,
  input  logic [VALUE_W-1:0] load_value,
  input  logic [VALUE_W-1:0] fill_low,
  input  logic [VALUE_W-1:0] fill_high,
  output logic [VALUE_W-1:0] tap_low,
  output logic [VALUE_W-1:0] tap_high
);

  logic [VALUE_W-1:0] cell_value [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] lower;
    logic [VALUE_W-1:0] upper;
    logic               hit;

    if (i == 0) begin : g_first
      assign lower = fill_low;
    end else begin : g_mid_low
      assign lower = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = fill_high;
    end else begin : g_mid_high
      assign upper = cell_value[i+1];
    end

    assign hit = ctl.load_en && (ctl.load_index == IDX_W'(i));

    deq_cell u_cell (
      .clk        (clk),
      .op         (ctl.op),
      .load       (hit),
      .load_value (load_value),
      .lower      (lower),
      .upper      (upper),
      .value      (cell_value[i])
    );
  end

  assign tap_low  = cell_value[0];
  assign tap_high = cell_value[DEPTH-1];

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 32-bit values kept in two mirrored rows of shift cells.
//
// Push and pop: the result is registered in the cycle after the item is taken.
// Listing: one result per stored entry per cycle while the receiver takes results;
//   the row for the listing direction rotates in place and the input is held until the last one.
// Unused command codes are taken and give no result.
// Reset empties the queue and drops any pending result; the cells keep data.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [VALUE_W-1:0]  item_value,
  output logic                result_valid,
  input  logic                result_ready,
  output logic [VALUE_W-1:0]  result_value,
  output logic [STATUS_W-1:0] status,
  output logic                last_of_run,
  output logic [OCC_W-1:0]    occupancy
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // row a keeps the front at cell 0, row b keeps the rear at the top cell
  deq_state_t         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   list_left, list_left_next;
  logic               list_back, list_back_next;

  cmd_t               cmd;
  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;

  chain_ctl_t         ctl_a, ctl_b;
  logic [VALUE_W-1:0] load_a, load_b;
  logic [VALUE_W-1:0] tap_a, tap_b;

  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  logic [STATUS_W-1:0] emit_status;
  logic               emit_last;

  assign cmd        = cmd_t'(command);
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE) && out_free;
  assign accept     = item_valid && item_ready;
  assign full       = (count == DEPTH_C);
  assign empty      = (count == '0);

  deq_chain u_row_a (
    .clk        (clk),
    .ctl        (ctl_a),
    .load_value (load_a),
    .fill_low   (item_value),
    .fill_high  (item_value),
    .tap_low    (tap_a),
    .tap_high   ()
  );

  deq_chain u_row_b (
    .clk        (clk),
    .ctl        (ctl_b),
    .load_value (load_b),
    .fill_low   (item_value),
    .fill_high  (item_value),
    .tap_low    (),
    .tap_high   (tap_b)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    list_left_next = list_left;
    list_back_next = list_back;
    ctl_a          = '{op: CELL_HOLD, load_en: 1'b0, load_index: '0};
    ctl_b          = '{op: CELL_HOLD, load_en: 1'b0, load_index: '0};
    load_a         = item_value;
    load_b         = item_value;
    emit           = 1'b0;
    emit_value     = '0;
    emit_status    = STAT_OK;
    emit_last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd) inside
            CMD_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                ctl_a.op         = CELL_UP;
                ctl_b.load_en    = 1'b1;
                ctl_b.load_index = IDX_W'(DEPTH_C - ONE_C - count);
                count_next       = count + ONE_C;
              end
            end
            CMD_PUSH_REAR: begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                ctl_a.load_en    = 1'b1;
                ctl_a.load_index = count[IDX_W-1:0];
                ctl_b.op         = CELL_DOWN;
                count_next       = count + ONE_C;
              end
            end
            CMD_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                emit_value = tap_a;
                ctl_a.op   = CELL_DOWN;
                count_next = count - ONE_C;
              end
            end
            CMD_POP_REAR: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = STAT_EMPTY;
              end else begin
                emit_value = tap_b;
                ctl_b.op   = CELL_UP;
                count_next = count - ONE_C;
              end
            end
            CMD_LIST_FWD, CMD_LIST_BWD: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = STAT_EMPTY;
              end else begin
                state_next     = S_LIST;
                list_left_next = count;
                list_back_next = (cmd == CMD_LIST_BWD);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_last      = (list_left == ONE_C);
          list_left_next = list_left - ONE_C;
          // rotate the occupied span by one, the tap entry wraps to its far end
          if (list_back) begin
            emit_value       = tap_b;
            ctl_b.op         = CELL_UP;
            ctl_b.load_en    = 1'b1;
            ctl_b.load_index = IDX_W'(DEPTH_C - count);
            load_b           = tap_b;
          end else begin
            emit_value       = tap_a;
            ctl_a.op         = CELL_DOWN;
            ctl_a.load_en    = 1'b1;
            ctl_a.load_index = IDX_W'(count - ONE_C);
            load_a           = tap_a;
          end
          if (list_left == ONE_C) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      list_left <= '0;
      list_back <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      list_left <= list_left_next;
      list_back <= list_back_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_value <= emit_value;
      status       <= emit_status;
      last_of_run  <= emit_last;
      occupancy    <= OCC_W'(count_next);
    end
  end

endmodule

[rtl/deq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [VALUE_W-1:0]  result_value,
  input logic [STATUS_W-1:0] status,
  input logic                last_of_run,
  input logic [OCC_W-1:0]    occupancy
);

  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(DEPTH);

  logic                                stalled;
  logic                                is_full;
  logic                                is_empty;
  logic                                bare_last;
  logic [VALUE_W+STATUS_W+OCC_W:0]     payload;

  assign stalled   = result_valid && !result_ready;
  assign is_full   = result_valid && (status == STAT_FULL);
  assign is_empty  = result_valid && (status == STAT_EMPTY);
  assign bare_last = last_of_run && (result_value == '0);
  assign payload   = {result_value, status, last_of_run, occupancy};

  // a stalled item must not move
  `DEQ_ASSERT(a_result_hold, stalled |=> result_valid && $stable(payload), "result not held")

  `DEQ_ASSERT(a_full_occ, is_full |-> bare_last && occupancy == OCC_MAX, "bad full result")

  `DEQ_ASSERT(a_empty_occ, is_empty |-> bare_last && occupancy == '0, "bad empty result")

  `DEQ_ASSERT(a_occ_range, result_valid |-> occupancy <= OCC_MAX, "occupancy above depth")

  `DEQ_ASSERT_RST(a_reset_idle, rst |=> !result_valid, "result pending after reset")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue. Commands are driven through
// the valid/ready input while a behavioral deque predicts every result. Each
// result is compared field by field, in order, against the predicted ones.
// The run covers the empty and full corners, ignored command codes, listings
// in both directions, random traffic with idle cycles on both sides, a long
// receiver stall and a stretch with no idle cycles at all.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
  localparam int IDLE_PCT    = 36;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] stat;
    logic                last;
    logic [OCC_W-1:0]    occ;
  } deq_answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [CMD_W-1:0]    command = '0;
  logic [VALUE_W-1:0]  item_value = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;
  logic [OCC_W-1:0]    occupancy;

  // behavioral deque
  logic [VALUE_W-1:0] model_store [DEPTH];
  int                 model_front = 0;
  int                 model_count = 0;
  deq_answer_t        awaited_answers [$];

  bit idle_on = 1'b1;
  int hold_off_left = 0;
  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int listings = 0;
  int full_pushes = 0;
  int empty_answers = 0;
  int ignored_items = 0;

  double_ended_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .item_value   (item_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_value (result_value),
    .status       (status),
    .last_of_run  (last_of_run),
    .occupancy    (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic add_answer(input logic [VALUE_W-1:0] value, input logic [STATUS_W-1:0] stat,
                            input logic last);
    deq_answer_t a;
    a.value = value;
    a.stat  = stat;
    a.last  = last;
    a.occ   = model_count[OCC_W-1:0];
    awaited_answers.push_back(a);
  endtask

  task automatic predict_deque_answers(input logic [CMD_W-1:0] cmd,
                                       input logic [VALUE_W-1:0] val);
    int pos;
    logic [VALUE_W-1:0] taken;
    case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (model_count >= DEPTH) begin
          full_pushes++;
          add_answer('0, STAT_FULL, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            model_front = (model_front + DEPTH - 1) % DEPTH;
            model_store[model_front] = val;
          end else begin
            model_store[(model_front + model_count) % DEPTH] = val;
          end
          model_count++;
          add_answer('0, STAT_OK, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (model_count == 0) begin
          empty_answers++;
          add_answer('0, STAT_EMPTY, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            taken = model_store[model_front];
            model_front = (model_front + 1) % DEPTH;
          end else begin
            taken = model_store[(model_front + model_count - 1) % DEPTH];
          end
          model_count--;
          add_answer(taken, STAT_OK, 1'b1);
        end
      end
      CMD_LIST_FWD, CMD_LIST_BWD: begin
        listings++;
        if (model_count == 0) begin
          empty_answers++;
          add_answer('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < model_count; k++) begin
            pos = (cmd == CMD_LIST_FWD) ? (model_front + k) % DEPTH
                                        : (model_front + model_count - 1 - k) % DEPTH;
            add_answer(model_store[pos], STAT_OK, k == model_count - 1);
          end
        end
      end
      default: ignored_items++;
    endcase
  endtask

  // one item through the input handshake, predicted once it is taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command    <= cmd;
    item_value <= val;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_deque_answers(cmd, val);
    items_sent++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_push();
    return ($urandom_range(1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
  endfunction

  function automatic logic [CMD_W-1:0] pick_pop();
    return ($urandom_range(1) == 0) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  task automatic test_empty_queue();
    send_item(CMD_POP_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_POP_REAR, 32'h1234_5678);
    send_item(CMD_LIST_FWD, '0);
    send_item(CMD_LIST_BWD, '0);
    send_item(CMD_RSVD_6, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_7, 32'h0000_0001);
  endtask

  task automatic test_edge_values();
    send_item(CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'h8000_0000);
    send_item(CMD_PUSH_REAR, 32'hFFFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'h0000_0000);
    send_item(CMD_PUSH_REAR, 32'h0000_0001);
    send_item(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(CMD_RSVD_7, 32'h5555_5555);
    send_item(CMD_LIST_FWD, '0);
    send_item(CMD_LIST_BWD, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_REAR, '0);
    send_item(CMD_LIST_FWD, '0);
    repeat (4) send_item(pick_pop(), $urandom);
    send_item(CMD_POP_REAR, '0);
    // single entry seen from both ends
    send_item(CMD_PUSH_FRONT, 32'h5555_5555);
    send_item(CMD_POP_REAR, '0);
  endtask

  task automatic test_full_queue();
    hold_off_left = 150;  // receiver stalls while pushes keep coming
    while (model_count < DEPTH) send_item(pick_push(), pick_value());
    send_item(CMD_PUSH_FRONT, pick_value());
    send_item(CMD_PUSH_REAR, pick_value());
    send_item(CMD_LIST_FWD, $urandom);
    send_item(CMD_LIST_BWD, $urandom);
    repeat (24) send_item(pick_pop(), $urandom);
  endtask

  task automatic test_random_mix(input int n, input int push_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < push_pct) begin
        send_item(pick_push(), pick_value());
      end else if (r < 88) begin
        send_item(pick_pop(), $urandom);
      end else if (r < 97) begin
        send_item(($urandom_range(1) == 0) ? CMD_LIST_FWD : CMD_LIST_BWD, $urandom);
      end else begin
        send_item(($urandom_range(1) == 0) ? CMD_RSVD_6 : CMD_RSVD_7, $urandom);
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_mix(25, 55);
    idle_on = 1'b1;
  endtask

  // receiver side, with its own count of the long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_off_left > 0) begin
        result_ready <= 1'b0;
        hold_off_left--;
      end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_answers
    deq_answer_t want;
    if (!rst && result_valid && result_ready) begin
      results_checked++;
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result value %h status %0d last %0b occupancy %0d",
                   $time, result_value, status, last_of_run, occupancy);
      end else begin
        want = awaited_answers.pop_front();
        if (result_value !== want.value || status !== want.stat ||
            last_of_run !== want.last || occupancy !== want.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch, expected value %h status %0d last %0b occupancy %0d,",
                      " got value %h status %0d last %0b occupancy %0d"},
                     $time, want.value, want.stat, want.last, want.occ,
                     result_value, status, last_of_run, occupancy);
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_edge_values();
    test_full_queue();
    test_random_mix(40, 30);
    test_steady_stream();

    @(negedge clk);
    item_valid <= 1'b0;
    wait_cycles = 0;
    while (awaited_answers.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $display("%0d expected results never arrived", awaited_answers.size());
      mismatches += awaited_answers.size();
    end

    $display("sent %0d items: %0d listings, %0d pushes while full, %0d empty answers, %0d ignored",
             items_sent, listings, full_pushes, empty_answers, ignored_items);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d results outstanding", awaited_answers.size());
    $display("double_ended_queue regression: fail");
    $finish;
  end

endmodule
